@@ src/imgds_pkg.sv @@
// ----------------------------------------------------------------------------
// imgds_pkg
// shared types and constants of the 2x2 box downsampler
// ----------------------------------------------------------------------------
package imgds_pkg;

    // defaults of the top level parameters
    localparam int unsigned MAX_OUT_WIDTH_DEF = 1024;
    localparam int unsigned CHANNEL_BITS_DEF  = 8;
    localparam int unsigned CHANNELS_DEF      = 4;

    // channel fields on the ports
    localparam int unsigned PORT_CHANNELS = 4;

    // position counters
    localparam int unsigned COL_W          = 11;
    localparam int unsigned ROW_W          = 13;
    localparam int unsigned MAX_OUT_HEIGHT = 4096;

    // register widths
    localparam int unsigned OUT_WIDTH_W  = 11;
    localparam int unsigned OUT_HEIGHT_W = 13;
    localparam int unsigned CH_COUNT_W   = 3;

    // register reset values
    localparam logic [OUT_WIDTH_W-1:0]  OUT_WIDTH_RST      = 11'd1;
    localparam logic [OUT_HEIGHT_W-1:0] OUT_HEIGHT_RST     = 13'd1;
    localparam logic [CH_COUNT_W-1:0]   CHANNEL_COUNT_RST  = 3'd4;
    localparam logic                    SIGNED_SAMPLES_RST = 1'b0;

    // configuration port
    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    typedef enum logic [1:0] {
        REG_OUT_WIDTH      = 2'd0,
        REG_OUT_HEIGHT     = 2'd1,
        REG_CHANNEL_COUNT  = 2'd2,
        REG_SIGNED_SAMPLES = 2'd3
    } t_reg_idx;

endpackage

@@ src/image_2x2_box_downsample.sv @@
// ----------------------------------------------------------------------------
// image_2x2_box_downsample
// 2x2 box filter with decimation by two in both directions
// ----------------------------------------------------------------------------
// Pixels enter on the input channel (i_valid / o_stall) in raster order, one
// transfer per pixel, with up to four channels i_ch0..i_ch3. For each 2x2
// block one pixel of the half-size image leaves on the output channel
// (o_valid / i_stall): o_avg0..o_avg3 = (sum of four samples + 2) >> 2, with
// o_row_end on the last pixel of an output row and o_frame_end on the last
// pixel of the image. Sizes, channel count and signedness come from the
// APB registers; write them only while no pixel is in flight.
// Throughput: one pixel per cycle while the receiver does not stall. The pair-sum
// line buffer is a single-port memory that is either written (even rows) or
// read (odd rows) once per pixel pair. The pair sum that completes a block is
// registered in stage 1 together with the line buffer read; the block sum is
// then formed, rounded and taken into the output register.
// When the receiver stalls, the output register holds its result and the
// middle stage still takes one more result; only then is the input stalled.
// Reset clears the registers to their defaults, the position counters and
// the pipeline; the line buffer needs no clearing since each entry is
// written on an even row before the odd row reads it.
// ----------------------------------------------------------------------------
module image_2x2_box_downsample #(
    parameter int unsigned MAX_OUT_WIDTH = imgds_pkg::MAX_OUT_WIDTH_DEF,
    parameter int unsigned CHANNEL_BITS  = imgds_pkg::CHANNEL_BITS_DEF,
    parameter int unsigned CHANNELS      = imgds_pkg::CHANNELS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [imgds_pkg::PADDR_W-1:0]     paddr,
    input  logic [imgds_pkg::PDATA_W-1:0]     pwdata,
    output logic [imgds_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready,
    // pixel input
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [CHANNEL_BITS-1:0]           i_ch0,
    input  logic [CHANNEL_BITS-1:0]           i_ch1,
    input  logic [CHANNEL_BITS-1:0]           i_ch2,
    input  logic [CHANNEL_BITS-1:0]           i_ch3,
    // pixel output
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [CHANNEL_BITS-1:0]           o_avg0,
    output logic [CHANNEL_BITS-1:0]           o_avg1,
    output logic [CHANNEL_BITS-1:0]           o_avg2,
    output logic [CHANNEL_BITS-1:0]           o_avg3,
    output logic                              o_row_end,
    output logic                              o_frame_end
);
    import imgds_pkg::*;

    // pair and block sums are kept modulo 2^(CHANNEL_BITS+2), enough for the
    // result bits [CHANNEL_BITS+1:2] in either signedness
    localparam int unsigned SB      = CHANNEL_BITS + 2;
    localparam int unsigned ENTRY_W = CHANNELS * SB;
    localparam int unsigned AW      = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
    localparam int unsigned WMAX_W  = ($clog2(MAX_OUT_WIDTH + 1) > OUT_WIDTH_W) ?
                                      $clog2(MAX_OUT_WIDTH + 1) : OUT_WIDTH_W;
    localparam int unsigned COL_LIM_W = WMAX_W + 1;
    localparam int unsigned ROW_LIM_W = ROW_W + 1;

    function automatic logic [SB-1:0] widen(input logic [CHANNEL_BITS-1:0] x,
                                            input logic sgn);
        return {{2{sgn & x[CHANNEL_BITS-1]}}, x};
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [OUT_WIDTH_W-1:0]  r_out_width;
    logic [OUT_HEIGHT_W-1:0] r_out_height;
    logic [CH_COUNT_W-1:0]   r_channel_count;
    logic                    r_signed_samples;
    logic                    cfg_wr;
    t_reg_idx                reg_idx;

    assign reg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign cfg_wr  = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_width      <= OUT_WIDTH_RST;
            r_out_height     <= OUT_HEIGHT_RST;
            r_channel_count  <= CHANNEL_COUNT_RST;
            r_signed_samples <= SIGNED_SAMPLES_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_OUT_WIDTH:      r_out_width      <= pwdata[OUT_WIDTH_W-1:0];
                REG_OUT_HEIGHT:     r_out_height     <= pwdata[OUT_HEIGHT_W-1:0];
                REG_CHANNEL_COUNT:  r_channel_count  <= pwdata[CH_COUNT_W-1:0];
                REG_SIGNED_SAMPLES: r_signed_samples <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_OUT_WIDTH:      prdata = PDATA_W'(r_out_width);
            REG_OUT_HEIGHT:     prdata = PDATA_W'(r_out_height);
            REG_CHANNEL_COUNT:  prdata = PDATA_W'(r_channel_count);
            REG_SIGNED_SAMPLES: prdata = PDATA_W'(r_signed_samples);
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // effective sizes
    // ------------------------------------------------------------------
    logic [COL_LIM_W-1:0]  w_raw;
    logic [COL_LIM_W-1:0]  w_eff;
    logic [ROW_LIM_W-1:0]  h_raw;
    logic [ROW_LIM_W-1:0]  h_eff;
    logic [CH_COUNT_W-1:0] nc_eff;

    assign w_raw = COL_LIM_W'(r_out_width);
    assign h_raw = ROW_LIM_W'(r_out_height);

    always_comb begin
        if (w_raw == '0)
            w_eff = COL_LIM_W'(1);
        else if (w_raw > COL_LIM_W'(MAX_OUT_WIDTH))
            w_eff = COL_LIM_W'(MAX_OUT_WIDTH);
        else
            w_eff = w_raw;

        if (h_raw == '0)
            h_eff = ROW_LIM_W'(1);
        else if (h_raw > ROW_LIM_W'(MAX_OUT_HEIGHT))
            h_eff = ROW_LIM_W'(MAX_OUT_HEIGHT);
        else
            h_eff = h_raw;

        if (r_channel_count == '0)
            nc_eff = CH_COUNT_W'(1);
        else if (r_channel_count > CH_COUNT_W'(CHANNELS))
            nc_eff = CH_COUNT_W'(CHANNELS);
        else
            nc_eff = r_channel_count;
    end

    // ------------------------------------------------------------------
    // pipeline handshake
    // ------------------------------------------------------------------
    logic r_s1_valid;
    logic r_o_valid;
    logic s2_free;
    logic in_acc;

    assign s2_free = !r_o_valid || !i_stall;
    assign o_stall = r_s1_valid && !s2_free;
    assign in_acc  = i_valid && !o_stall;
    assign o_valid = r_o_valid;

    // ------------------------------------------------------------------
    // position tracking
    // ------------------------------------------------------------------
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [AW-1:0]    r_slot, n_slot;
    logic             last_col, last_row, odd_col, odd_row, emit;

    assign odd_col  = r_col[0];
    assign odd_row  = r_row[0];
    assign last_col = (COL_LIM_W'(r_col) + COL_LIM_W'(1)) >= (w_eff << 1);
    assign last_row = (ROW_LIM_W'(r_row) + ROW_LIM_W'(1)) >= (h_eff << 1);
    assign emit     = odd_col && odd_row;

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_slot = r_slot;
        if (in_acc) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
            // slot is the pair index modulo the line depth, restarting with the column
            if (last_col || (&r_col))
                n_slot = '0;
            else if (odd_col)
                n_slot = (r_slot == AW'(MAX_OUT_WIDTH - 1)) ? '0 : r_slot + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_slot <= n_slot;
        end
    end

    // ------------------------------------------------------------------
    // held pixel and pair sums
    // ------------------------------------------------------------------
    logic [CHANNEL_BITS-1:0] in_px  [PORT_CHANNELS];
    logic [CHANNEL_BITS-1:0] r_held [CHANNELS];
    logic [SB-1:0]           pair   [PORT_CHANNELS];
    logic [SB-1:0]           line_q [PORT_CHANNELS];
    logic [ENTRY_W-1:0]      wr_entry;
    logic [ENTRY_W-1:0]      r_line_q;

    assign in_px[0] = i_ch0;
    assign in_px[1] = i_ch1;
    assign in_px[2] = i_ch2;
    assign in_px[3] = i_ch3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CHANNELS; k++)
                r_held[k] <= '0;
        end else if (in_acc && !odd_col) begin
            for (int k = 0; k < CHANNELS; k++)
                r_held[k] <= in_px[k];
        end
    end

    for (genvar k = 0; k < PORT_CHANNELS; k++) begin : g_ch
        if (k < CHANNELS) begin : g_on
            assign pair[k] = widen(r_held[k], r_signed_samples)
                           + widen(in_px[k], r_signed_samples);
            assign wr_entry[k*SB +: SB] = pair[k];
            assign line_q[k] = r_line_q[k*SB +: SB];
        end else begin : g_off
            assign pair[k]   = '0;
            assign line_q[k] = '0;
        end
    end

    // ------------------------------------------------------------------
    // line buffer: written on even rows, read on odd rows, once per odd-column pixel
    // ------------------------------------------------------------------
    logic [ENTRY_W-1:0] r_line [MAX_OUT_WIDTH];
    logic               mem_we;
    logic               mem_re;

    assign mem_we = in_acc && odd_col && !odd_row;
    assign mem_re = in_acc && emit;

    always_ff @(posedge i_clk) begin
        if (mem_we)
            r_line[r_slot] <= wr_entry;
        else if (mem_re)
            r_line_q <= r_line[r_slot];
    end

    // ------------------------------------------------------------------
    // stage 1: pair of the odd row waits for the line buffer read
    // ------------------------------------------------------------------
    logic [SB-1:0]            r_s1_pair [PORT_CHANNELS];
    logic [PORT_CHANNELS-1:0] r_s1_mask, n_s1_mask;
    logic                     r_s1_row_end;
    logic                     r_s1_frame_end;

    always_comb begin
        for (int k = 0; k < PORT_CHANNELS; k++)
            n_s1_mask[k] = CH_COUNT_W'(k) < nc_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_s1_valid <= 1'b0;
        else if (!r_s1_valid || s2_free)
            r_s1_valid <= mem_re;
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            for (int k = 0; k < PORT_CHANNELS; k++)
                r_s1_pair[k] <= pair[k];
            r_s1_mask      <= n_s1_mask;
            r_s1_row_end   <= last_col;
            r_s1_frame_end <= last_col && last_row;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: block sum, rounding and output register
    // ------------------------------------------------------------------
    logic [SB-1:0]           total [PORT_CHANNELS];
    logic [CHANNEL_BITS-1:0] r_avg [PORT_CHANNELS];
    logic [CHANNEL_BITS-1:0] n_avg [PORT_CHANNELS];
    logic                    r_row_end;
    logic                    r_frame_end;

    always_comb begin
        for (int k = 0; k < PORT_CHANNELS; k++) begin
            total[k] = line_q[k] + r_s1_pair[k] + SB'(2);
            n_avg[k] = r_s1_mask[k] ? total[k][SB-1:2] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_o_valid <= 1'b0;
        else if (s2_free)
            r_o_valid <= r_s1_valid;
    end

    always_ff @(posedge i_clk) begin
        if (s2_free && r_s1_valid) begin
            for (int k = 0; k < PORT_CHANNELS; k++)
                r_avg[k] <= n_avg[k];
            r_row_end   <= r_s1_row_end;
            r_frame_end <= r_s1_frame_end;
        end
    end

    assign o_avg0      = r_avg[0];
    assign o_avg1      = r_avg[1];
    assign o_avg2      = r_avg[2];
    assign o_avg3      = r_avg[3];
    assign o_row_end   = r_row_end;
    assign o_frame_end = r_frame_end;

endmodule
